### rtl/spoc_pkg.sv
// ----------------------------------------------------------------------------
// spoc_pkg
// Shared types, codes and helpers of the sparse outer product accumulator.
// ----------------------------------------------------------------------------
package spoc_pkg;

    localparam int IDX_W = 15;
    localparam int CRD_W = 17;
    localparam int OFF_W = 16;
    localparam int SUM_W = 64;
    localparam int FAC_W = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_A = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_B = 3'd2;
    localparam logic [OP_W-1:0] OP_AXA    = 3'd3;
    localparam logic [OP_W-1:0] OP_AXB    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    localparam logic [ST_W-1:0] ST_ACCUM   = 3'd0;
    localparam logic [ST_W-1:0] ST_NEW     = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_POS = 3'd3;
    localparam logic [ST_W-1:0] ST_VEC_FUL = 3'd4;
    localparam logic [ST_W-1:0] ST_DONE    = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0] key_row;
        logic [IDX_W-1:0] key_col;
        logic [CRD_W-1:0] out_row;
        logic [CRD_W-1:0] out_col;
        logic [SUM_W-1:0] sum;
    } t_entry;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic clear;
        logic rd_b;
    } t_vec_ctl;

    // two's complement add clamped to the signed 64-bit range
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

### rtl/spoc_if.sv
// ----------------------------------------------------------------------------
// spoc_in_if / spoc_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface spoc_in_if #(parameter int POS_W = 10);
    logic                         valid;
    logic                         ready;
    logic [spoc_pkg::OP_W-1:0]    op;
    logic [spoc_pkg::IDX_W-1:0]   row;
    logic [spoc_pkg::IDX_W-1:0]   col;
    logic signed [spoc_pkg::SUM_W-1:0] pair_value;
    logic [spoc_pkg::IDX_W-1:0]   elem_index;
    logic signed [spoc_pkg::FAC_W-1:0] factor;
    logic [POS_W-1:0]             position;

    modport source (output valid, op, row, col, pair_value, elem_index, factor, position,
                    input ready);
    modport sink   (input valid, op, row, col, pair_value, elem_index, factor, position,
                    output ready);
endinterface

interface spoc_out_if #(parameter int POS_W = 10, parameter int CNT_W = 11);
    logic                         valid;
    logic                         ready;
    logic [spoc_pkg::ST_W-1:0]    status;
    logic [POS_W-1:0]             entry_position;
    logic [spoc_pkg::CRD_W-1:0]   out_row;
    logic [spoc_pkg::CRD_W-1:0]   out_col;
    logic signed [spoc_pkg::SUM_W-1:0] out_sum;
    logic [CNT_W-1:0]             entries_used;

    modport source (output valid, status, entry_position, out_row, out_col, out_sum,
                    entries_used, input ready);
    modport sink   (input valid, status, entry_position, out_row, out_col, out_sum,
                    entries_used, output ready);
endinterface

### rtl/sparse_outer_product_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_outer_product_accumulator
// Keyed sparse matrix accumulator with vector outer products.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       contents
//  i_item    in   valid/ready     op, row, col, pair_value, elem_index, factor, position
//  o_result  out  valid/ready     status, entry_position, out_row, out_col, out_sum,
//                                 entries_used
//  apb       in   psel/penable    row_offset at 0x0, col_offset at 0x4
//
//  one item at a time: no new item is taken until the last result is loaded for output
//  op 0 scans the entry store one stored entry at a time (one memory read port)
//  op 3/4 steps per product: load b, multiply, one scan and next step (with a load
//  of a first at a new row of vector a)
//  reset clears counts and vector lengths; no memory clearing pass
//  a stalled result holds the block in its response state
// ----------------------------------------------------------------------------
module sparse_outer_product_accumulator #(
    parameter int ENTRY_CAPACITY = 1024,
    parameter int VECTOR_MAX     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spoc_in_if.sink     i_item,
    spoc_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(ENTRY_CAPACITY);
    localparam int CNT_W = $clog2(ENTRY_CAPACITY + 1);
    localparam int LEN_W = $clog2(VECTOR_MAX + 1);
    localparam int VA_W  = $clog2(VECTOR_MAX);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(ENTRY_CAPACITY);
    localparam logic [LEN_W-1:0] VMX = LEN_W'(VECTOR_MAX);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOADA = 10'b0000000010,
        S_LOADB = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_RD    = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_NEXT  = 10'b0001000000,
        S_RDPOS = 10'b0010000000,
        S_RESP  = 10'b0100000000,
        S_HOLD  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [spoc_pkg::OFF_W-1:0] r_row_off, r_col_off;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_k, n_k;
    logic [LEN_W-1:0]           r_i, n_i, r_j, n_j;
    logic [spoc_pkg::OP_W-1:0]  r_op, n_op;
    logic [spoc_pkg::IDX_W-1:0] r_tr, n_tr, r_tc, n_tc, r_ai, n_ai;
    logic [spoc_pkg::FAC_W-1:0] r_af, n_af, r_bf, n_bf;
    logic [spoc_pkg::SUM_W-1:0] r_val, n_val;
    logic                       r_drop, n_drop;

    logic [spoc_pkg::ST_W-1:0]  r_res_st, n_res_st;
    logic [POS_W-1:0]           r_res_pos, n_res_pos;
    logic [spoc_pkg::CRD_W-1:0] r_res_row, n_res_row, r_res_col, n_res_col;
    logic [spoc_pkg::SUM_W-1:0] r_res_sum, n_res_sum;

    logic                       r_ovalid;
    logic [spoc_pkg::ST_W-1:0]  r_o_st;
    logic [POS_W-1:0]           r_o_pos;
    logic [spoc_pkg::CRD_W-1:0] r_o_row, r_o_col;
    logic [spoc_pkg::SUM_W-1:0] r_o_sum;
    logic [CNT_W-1:0]           r_o_cnt;

    logic               mem_we, mem_re;
    logic [POS_W-1:0]   mem_waddr, mem_raddr;
    spoc_pkg::t_entry   mem_wdata, mem_rdata;

    spoc_pkg::t_vec_ctl         vctl;
    logic [VA_W-1:0]            v_addr;
    logic [spoc_pkg::IDX_W-1:0] v_idx;
    logic [spoc_pkg::FAC_W-1:0] v_fac;
    logic [LEN_W-1:0]           a_len, b_len, n2;

    logic signed [2*spoc_pkg::FAC_W-1:0] prod;

    logic accept, load_out, key_hit;

    // config port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_col_off} : {16'd0, r_row_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_off <= '0;
            r_col_off <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_col_off <= pwdata[spoc_pkg::OFF_W-1:0];
            end else begin
                r_row_off <= pwdata[spoc_pkg::OFF_W-1:0];
            end
        end
    end

    spoc_entry_mem #(.DEPTH(ENTRY_CAPACITY), .AW(POS_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    spoc_vec_store #(.VMAX(VECTOR_MAX), .LEN_W(LEN_W), .VA_W(VA_W)) u_vec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (vctl),
        .i_idx     (i_item.elem_index),
        .i_fac     (i_item.factor),
        .i_rd_addr (v_addr),
        .o_rd_idx  (v_idx),
        .o_rd_fac  (v_fac),
        .o_a_len   (a_len),
        .o_b_len   (b_len)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign load_out     = (r_state == S_RESP) && (!r_ovalid || o_result.ready);
    assign n2           = (r_op == spoc_pkg::OP_AXA) ? a_len : b_len;
    assign key_hit      = (mem_rdata.key_row == r_tr) && (mem_rdata.key_col == r_tc);
    // signed q16.16 times q16.16 is exact in q32.32
    assign prod         = $signed(r_af) * $signed(r_bf);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_op      = r_op;
        n_tr      = r_tr;
        n_tc      = r_tc;
        n_ai      = r_ai;
        n_af      = r_af;
        n_bf      = r_bf;
        n_val     = r_val;
        n_drop    = r_drop;
        n_res_st  = r_res_st;
        n_res_pos = r_res_pos;
        n_res_row = r_res_row;
        n_res_col = r_res_col;
        n_res_sum = r_res_sum;
        mem_we    = 1'b0;
        mem_waddr = r_count[POS_W-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_k[POS_W-1:0];
        vctl      = '0;
        v_addr    = r_i[VA_W-1:0];

        case (r_state)
            S_IDLE: begin
                mem_raddr = i_item.position;
                if (accept) begin
                    n_op      = i_item.op;
                    n_res_st  = spoc_pkg::ST_DONE;
                    n_res_pos = '0;
                    n_res_row = '0;
                    n_res_col = '0;
                    n_res_sum = '0;
                    n_drop    = 1'b0;
                    n_k       = '0;
                    n_i       = '0;
                    n_j       = '0;
                    n_state   = S_RESP;
                    case (i_item.op)
                        spoc_pkg::OP_ADD: begin
                            n_tr    = i_item.row;
                            n_tc    = i_item.col;
                            n_val   = i_item.pair_value;
                            n_state = S_RD;
                        end
                        spoc_pkg::OP_PUSH_A: begin
                            if (a_len == VMX) begin
                                n_res_st = spoc_pkg::ST_VEC_FUL;
                            end else begin
                                vctl.push_a = 1'b1;
                            end
                        end
                        spoc_pkg::OP_PUSH_B: begin
                            if (b_len == VMX) begin
                                n_res_st = spoc_pkg::ST_VEC_FUL;
                            end else begin
                                vctl.push_b = 1'b1;
                            end
                        end
                        spoc_pkg::OP_AXA, spoc_pkg::OP_AXB: begin
                            if (a_len == '0 ||
                                (i_item.op == spoc_pkg::OP_AXA ? a_len : b_len) == '0) begin
                                vctl.clear = 1'b1;
                            end else begin
                                n_state = S_LOADA;
                            end
                        end
                        spoc_pkg::OP_READ: begin
                            n_res_pos = i_item.position;
                            if (CNT_W'(i_item.position) >= r_count) begin
                                n_res_st = spoc_pkg::ST_BAD_POS;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_RDPOS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOADA: begin
                v_addr  = r_i[VA_W-1:0];
                n_ai    = v_idx;
                n_af    = v_fac;
                n_state = S_LOADB;
            end
            S_LOADB: begin
                v_addr     = r_j[VA_W-1:0];
                vctl.rd_b  = (r_op == spoc_pkg::OP_AXB);
                n_tc       = v_idx;
                n_bf       = v_fac;
                n_state    = S_MUL;
            end
            S_MUL: begin
                n_val   = prod;
                n_tr    = r_ai;
                n_k     = '0;
                n_state = S_RD;
            end
            S_RD: begin
                if (r_k == r_count) begin
                    // key not present: append or drop
                    if (r_count == CAP) begin
                        n_drop    = 1'b1;
                        n_res_st  = spoc_pkg::ST_FULL;
                        n_res_pos = '0;
                    end else begin
                        mem_we            = 1'b1;
                        mem_wdata.key_row = r_tr;
                        mem_wdata.key_col = r_tc;
                        mem_wdata.out_row = {2'b00, r_tr} + {1'b0, r_row_off};
                        mem_wdata.out_col = {2'b00, r_tc} + {1'b0, r_col_off};
                        mem_wdata.sum     = r_val;
                        n_count           = r_count + 1'b1;
                        n_res_st          = spoc_pkg::ST_NEW;
                        n_res_pos         = r_count[POS_W-1:0];
                    end
                    n_state = (r_op == spoc_pkg::OP_ADD) ? S_RESP : S_NEXT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (key_hit) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_k[POS_W-1:0];
                    mem_wdata     = mem_rdata;
                    mem_wdata.sum = spoc_pkg::sat_add(mem_rdata.sum, r_val);
                    n_res_st      = spoc_pkg::ST_ACCUM;
                    n_res_pos     = r_k[POS_W-1:0];
                    n_state       = (r_op == spoc_pkg::OP_ADD) ? S_RESP : S_NEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_NEXT: begin
                if (r_j + 1'b1 < n2) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_LOADB;
                end else if (r_i + 1'b1 < a_len) begin
                    n_i     = r_i + 1'b1;
                    n_j     = '0;
                    n_state = S_LOADA;
                end else begin
                    vctl.clear = 1'b1;
                    n_res_st   = r_drop ? spoc_pkg::ST_FULL : spoc_pkg::ST_DONE;
                    n_res_pos  = '0;
                    n_state    = S_RESP;
                end
            end
            S_RDPOS: begin
                n_res_row = mem_rdata.out_row;
                n_res_col = mem_rdata.out_col;
                n_res_sum = mem_rdata.sum;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            S_HOLD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_i       <= n_i;
        r_j       <= n_j;
        r_op      <= n_op;
        r_tr      <= n_tr;
        r_tc      <= n_tc;
        r_ai      <= n_ai;
        r_af      <= n_af;
        r_bf      <= n_bf;
        r_val     <= n_val;
        r_drop    <= n_drop;
        r_res_st  <= n_res_st;
        r_res_pos <= n_res_pos;
        r_res_row <= n_res_row;
        r_res_col <= n_res_col;
        r_res_sum <= n_res_sum;
        if (load_out) begin
            r_o_st  <= r_res_st;
            r_o_pos <= r_res_pos;
            r_o_row <= r_res_row;
            r_o_col <= r_res_col;
            r_o_sum <= r_res_sum;
            r_o_cnt <= r_count;
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.status         = r_o_st;
    assign o_result.entry_position = r_o_pos;
    assign o_result.out_row        = r_o_row;
    assign o_result.out_col        = r_o_col;
    assign o_result.out_sum        = r_o_sum;
    assign o_result.entries_used   = r_o_cnt;

endmodule

### rtl/spoc_entry_mem.sv
// ----------------------------------------------------------------------------
// spoc_entry_mem
// Entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spoc_entry_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  spoc_pkg::t_entry     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output spoc_pkg::t_entry     o_rdata
);

    spoc_pkg::t_entry r_mem [DEPTH];
    spoc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/spoc_vec_store.sv
// ----------------------------------------------------------------------------
// spoc_vec_store
// Vectors A and B of index/factor pairs with their lengths.
// ----------------------------------------------------------------------------
module spoc_vec_store #(
    parameter int VMAX  = 8,
    parameter int LEN_W = 4,
    parameter int VA_W  = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spoc_pkg::t_vec_ctl            i_ctl,
    input  logic [spoc_pkg::IDX_W-1:0]    i_idx,
    input  logic [spoc_pkg::FAC_W-1:0]    i_fac,
    input  logic [VA_W-1:0]               i_rd_addr,
    output logic [spoc_pkg::IDX_W-1:0]    o_rd_idx,
    output logic [spoc_pkg::FAC_W-1:0]    o_rd_fac,
    output logic [LEN_W-1:0]              o_a_len,
    output logic [LEN_W-1:0]              o_b_len
);

    logic [spoc_pkg::IDX_W-1:0] r_a_idx [VMAX];
    logic [spoc_pkg::FAC_W-1:0] r_a_fac [VMAX];
    logic [spoc_pkg::IDX_W-1:0] r_b_idx [VMAX];
    logic [spoc_pkg::FAC_W-1:0] r_b_fac [VMAX];
    logic [LEN_W-1:0]           r_a_len;
    logic [LEN_W-1:0]           r_b_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_len <= '0;
            r_b_len <= '0;
        end else if (i_ctl.clear) begin
            r_a_len <= '0;
            r_b_len <= '0;
        end else begin
            if (i_ctl.push_a) begin
                r_a_len <= r_a_len + 1'b1;
            end
            if (i_ctl.push_b) begin
                r_b_len <= r_b_len + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_a) begin
            r_a_idx[r_a_len[VA_W-1:0]] <= i_idx;
            r_a_fac[r_a_len[VA_W-1:0]] <= i_fac;
        end
        if (i_ctl.push_b) begin
            r_b_idx[r_b_len[VA_W-1:0]] <= i_idx;
            r_b_fac[r_b_len[VA_W-1:0]] <= i_fac;
        end
    end

    assign o_rd_idx = i_ctl.rd_b ? r_b_idx[i_rd_addr] : r_a_idx[i_rd_addr];
    assign o_rd_fac = i_ctl.rd_b ? r_b_fac[i_rd_addr] : r_a_fac[i_rd_addr];
    assign o_a_len  = r_a_len;
    assign o_b_len  = r_b_len;

endmodule

### bench/tb_sparse_outer_product_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_outer_product_accumulator
// Drives command items with random gaps and result stalls, predicts every
// result from a behavioral copy of the entry table and vectors, and compares
// each result field by field. Offsets are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_sparse_outer_product_accumulator;

    localparam int CAP   = 1024;
    localparam int VMAX  = 8;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 100;

    localparam int IDX_W = spoc_pkg::IDX_W;
    localparam int CRD_W = spoc_pkg::CRD_W;
    localparam int SUM_W = spoc_pkg::SUM_W;
    localparam int FAC_W = spoc_pkg::FAC_W;
    localparam int OP_W  = spoc_pkg::OP_W;
    localparam int ST_W  = spoc_pkg::ST_W;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [2:0] REG_ROW_OFFSET = 3'h0;
    localparam logic [2:0] REG_COL_OFFSET = 3'h4;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] entry_position;
        logic [CRD_W-1:0] out_row;
        logic [CRD_W-1:0] out_col;
        logic [SUM_W-1:0] out_sum;
        logic [CNT_W-1:0] entries_used;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] pair_value;
        logic [IDX_W-1:0] elem_index;
        logic [FAC_W-1:0] factor;
        logic [POS_W-1:0] position;
    } t_cmd;

    typedef struct {
        t_cmd    cmd;
        bit      has_fixed;
        t_result fixed;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    spoc_in_if  #(.POS_W(POS_W))               cmd_ch();
    spoc_out_if #(.POS_W(POS_W), .CNT_W(CNT_W)) res_ch();

    sparse_outer_product_accumulator #(.ENTRY_CAPACITY(CAP), .VECTOR_MAX(VMAX)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(cmd_ch.sink), .o_result(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [IDX_W-1:0] tbl_key_row [CAP];
    logic [IDX_W-1:0] tbl_key_col [CAP];
    logic [CRD_W-1:0] tbl_out_row [CAP];
    logic [CRD_W-1:0] tbl_out_col [CAP];
    logic [SUM_W-1:0] tbl_sum [CAP];
    int               tbl_count;
    logic [IDX_W-1:0] va_idx [VMAX];
    logic [FAC_W-1:0] va_fac [VMAX];
    int               va_len;
    logic [IDX_W-1:0] vb_idx [VMAX];
    logic [FAC_W-1:0] vb_fac [VMAX];
    int               vb_len;
    logic [15:0]      row_off, col_off;

    t_result pending_results[$];
    t_row    directed[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      no_idle = 1'b0;
    bit      hold_off = 1'b0;

    function automatic logic [SUM_W-1:0] clamp_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s;
    endfunction

    // returns the status of one keyed add; pos gets the entry touched
    function automatic logic [ST_W-1:0] table_add(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                                  logic [SUM_W-1:0] v, output int pos);
        for (int k = 0; k < tbl_count; k++) begin
            if (tbl_key_row[k] == r && tbl_key_col[k] == c) begin
                tbl_sum[k] = clamp_add(tbl_sum[k], v);
                pos = k;
                return spoc_pkg::ST_ACCUM;
            end
        end
        pos = 0;
        if (tbl_count >= CAP) return spoc_pkg::ST_FULL;
        pos = tbl_count;
        tbl_key_row[pos] = r;
        tbl_key_col[pos] = c;
        tbl_out_row[pos] = {2'b0, r} + {1'b0, row_off};
        tbl_out_col[pos] = {2'b0, c} + {1'b0, col_off};
        tbl_sum[pos] = v;
        tbl_count++;
        return spoc_pkg::ST_NEW;
    endfunction

    function automatic t_result predict_result(t_cmd c);
        t_result res;
        int pos, n2;
        logic signed [63:0] prod;
        logic [FAC_W-1:0] f2;
        logic [IDX_W-1:0] i2;
        res = '{spoc_pkg::ST_DONE, '0, '0, '0, '0, '0};
        case (c.op)
            spoc_pkg::OP_ADD: begin
                res.status = table_add(c.row, c.col, c.pair_value, pos);
                res.entry_position = pos[POS_W-1:0];
            end
            spoc_pkg::OP_PUSH_A: begin
                if (va_len >= VMAX) res.status = spoc_pkg::ST_VEC_FUL;
                else begin
                    va_idx[va_len] = c.elem_index;
                    va_fac[va_len] = c.factor;
                    va_len++;
                end
            end
            spoc_pkg::OP_PUSH_B: begin
                if (vb_len >= VMAX) res.status = spoc_pkg::ST_VEC_FUL;
                else begin
                    vb_idx[vb_len] = c.elem_index;
                    vb_fac[vb_len] = c.factor;
                    vb_len++;
                end
            end
            spoc_pkg::OP_AXA, spoc_pkg::OP_AXB: begin
                n2 = (c.op == spoc_pkg::OP_AXA) ? va_len : vb_len;
                for (int i = 0; i < va_len; i++) begin
                    for (int j = 0; j < n2; j++) begin
                        f2 = (c.op == spoc_pkg::OP_AXA) ? va_fac[j] : vb_fac[j];
                        i2 = (c.op == spoc_pkg::OP_AXA) ? va_idx[j] : vb_idx[j];
                        prod = $signed(va_fac[i]) * $signed(f2);
                        if (table_add(va_idx[i], i2, prod, pos) == spoc_pkg::ST_FULL)
                            res.status = spoc_pkg::ST_FULL;
                    end
                end
                va_len = 0;
                vb_len = 0;
            end
            spoc_pkg::OP_READ: begin
                res.entry_position = c.position;
                if (c.position >= tbl_count) res.status = spoc_pkg::ST_BAD_POS;
                else begin
                    res.out_row = tbl_out_row[c.position];
                    res.out_col = tbl_out_col[c.position];
                    res.out_sum = tbl_sum[c.position];
                end
            end
            default: ;
        endcase
        res.entries_used = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    task automatic add_row(t_cmd c, bit has_fixed, t_result fixed);
        t_row r;
        r.cmd = c;
        r.has_fixed = has_fixed;
        r.fixed = fixed;
        directed.insert(directed.size(), r);
    endtask

    task automatic check_fixed(int k, t_result got, t_result want);
        if (got.status !== want.status) begin
            $error("directed row %0d status exp %0d got %0d", k, want.status, got.status);
            error_count++;
        end
        if (got.entry_position !== want.entry_position) begin
            $error("directed row %0d entry_position exp %0d got %0d", k,
                   want.entry_position, got.entry_position);
            error_count++;
        end
        if (got.out_row !== want.out_row) begin
            $error("directed row %0d out_row exp %0d got %0d", k, want.out_row, got.out_row);
            error_count++;
        end
        if (got.out_col !== want.out_col) begin
            $error("directed row %0d out_col exp %0d got %0d", k, want.out_col, got.out_col);
            error_count++;
        end
        if (got.out_sum !== want.out_sum) begin
            $error("directed row %0d out_sum exp %h got %h", k, want.out_sum, got.out_sum);
            error_count++;
        end
        if (got.entries_used !== want.entries_used) begin
            $error("directed row %0d entries_used exp %0d got %0d", k,
                   want.entries_used, got.entries_used);
            error_count++;
        end
    endtask

    task automatic apb_write(logic [2:0] addr, logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_ROW_OFFSET) row_off = value;
        else col_off = value;
    endtask

    // valid stays high into the next item; callers drop it before waiting
    task automatic send_cmd(t_cmd c, bit allow_gap);
        while (allow_gap && !no_idle && $urandom_range(99) < 27) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op <= c.op; cmd_ch.row <= c.row; cmd_ch.col <= c.col;
        cmd_ch.pair_value <= c.pair_value; cmd_ch.elem_index <= c.elem_index;
        cmd_ch.factor <= c.factor; cmd_ch.position <= c.position;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic drain_results();
        wait_results();
        // an idle gap between phases
        repeat (50) @(negedge i_clk);
    endtask

    function automatic t_cmd rand_cmd(int well_formed);
        t_cmd c;
        int r;
        c.op = OP_W'($urandom_range(7));
        c.row = IDX_W'($urandom); c.col = IDX_W'($urandom);
        c.pair_value = {$urandom, $urandom};
        c.elem_index = IDX_W'($urandom);
        c.factor = $urandom;
        c.position = POS_W'($urandom);
        if (well_formed != 0) begin
            r = $urandom_range(99);
            // small key space so entries get hit again
            c.row = IDX_W'($urandom_range(7)); c.col = IDX_W'($urandom_range(7));
            c.elem_index = IDX_W'($urandom_range(7));
            if ($urandom_range(3) == 0) c.row = IDX_W'($urandom);
            if (r < 30) c.op = spoc_pkg::OP_ADD;
            else if (r < 48) c.op = spoc_pkg::OP_PUSH_A;
            else if (r < 62) c.op = spoc_pkg::OP_PUSH_B;
            else if (r < 70) c.op = spoc_pkg::OP_AXA;
            else if (r < 78) c.op = spoc_pkg::OP_AXB;
            else c.op = spoc_pkg::OP_READ;
            if (c.op == spoc_pkg::OP_READ && tbl_count > 0 && $urandom_range(4) != 0)
                c.position = POS_W'($urandom_range(tbl_count - 1));
        end
        return c;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item, status %0d", res_ch.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, res_ch.status); error_count++;
                end
                if (res_ch.entry_position !== want.entry_position) begin
                    $error("entry_position exp %0d got %0d", want.entry_position,
                           res_ch.entry_position);
                    error_count++;
                end
                if (res_ch.out_row !== want.out_row) begin
                    $error("out_row exp %0d got %0d", want.out_row, res_ch.out_row); error_count++;
                end
                if (res_ch.out_col !== want.out_col) begin
                    $error("out_col exp %0d got %0d", want.out_col, res_ch.out_col); error_count++;
                end
                if (res_ch.out_sum !== want.out_sum) begin
                    $error("out_sum exp %h got %h", want.out_sum, res_ch.out_sum); error_count++;
                end
                if (res_ch.entries_used !== want.entries_used) begin
                    $error("entries_used exp %0d got %0d", want.entries_used,
                           res_ch.entries_used);
                    error_count++;
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        t_cmd c;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c = '{cmd_ch.op, cmd_ch.row, cmd_ch.col, cmd_ch.pair_value, cmd_ch.elem_index,
                  cmd_ch.factor, cmd_ch.position};
            pending_results.insert(pending_results.size(), predict_result(c));
        end
    end

    // receiver stalls
    initial begin
        int hold_len;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_len = 300;
                res_ch.ready <= 1'b0;
                while (hold_len > 0) begin
                    @(negedge i_clk);
                    hold_len--;
                end
                hold_off = 1'b0;
            end
            res_ch.ready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    // watchdog on accepted items
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sparse_outer_product_accumulator");
            $finish;
        end
    end

    initial begin
        t_result got;
        t_cmd    c;
        int      sent;
        int      fill_round;

        cmd_ch.valid = 1'b0; cmd_ch.op = '0; cmd_ch.row = '0; cmd_ch.col = '0;
        cmd_ch.pair_value = '0; cmd_ch.elem_index = '0; cmd_ch.factor = '0;
        cmd_ch.position = '0;
        tbl_count = 0; va_len = 0; vb_len = 0; row_off = '0; col_off = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: fixed rows carry an expectation known at a glance
        add_row('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_BAD_POS, 0, 0, 0, 0, 0});
        add_row('{spoc_pkg::OP_AXA, 0, 0, 0, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_DONE, 0, 0, 0, 0, 0});
        add_row('{spoc_pkg::OP_AXB, 0, 0, 0, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_DONE, 0, 0, 0, 0, 0});
        add_row('{OP_SPARE_6, 0, 0, 0, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_DONE, 0, 0, 0, 0, 0});
        add_row('{OP_SPARE_7, '1, '1, '1, '1, '1, '1}, 1'b1,
                '{spoc_pkg::ST_DONE, 0, 0, 0, 0, 0});
        add_row('{spoc_pkg::OP_ADD, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_NEW, 0, 0, 0, 0, 1});
        add_row('{spoc_pkg::OP_ADD, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_ACCUM, 0, 0, 0, 0, 1});
        add_row('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, 0}, 1'b0, '{default: '0});
        add_row('{spoc_pkg::OP_ADD, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0}, 1'b1,
                '{spoc_pkg::ST_NEW, 1, 0, 0, 0, 2});
        add_row('{spoc_pkg::OP_ADD, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0}, 1'b0,
                '{default: '0});
        add_row('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, 1}, 1'b0, '{default: '0});
        add_row('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, '1}, 1'b1,
                '{spoc_pkg::ST_BAD_POS, '1, 0, 0, 0, 2});
        for (int k = 0; k < 9; k++)
            add_row('{spoc_pkg::OP_PUSH_A, 0, 0, 0, IDX_W'(k),
                      (k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF), 0}, 1'b1,
                    '{(k == 8) ? spoc_pkg::ST_VEC_FUL : spoc_pkg::ST_DONE, 0, 0, 0, 0, 2});
        add_row('{spoc_pkg::OP_PUSH_B, 0, 0, 0, '1, 32'h8000_0000, 0}, 1'b1,
                '{spoc_pkg::ST_DONE, 0, 0, 0, 0, 2});
        add_row('{spoc_pkg::OP_AXB, 0, 0, 0, 0, 0, 0}, 1'b0, '{default: '0});
        add_row('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, 2}, 1'b0, '{default: '0});

        apb_write(REG_ROW_OFFSET, 16'hFFFF);
        apb_write(REG_COL_OFFSET, 16'hFFFF);
        foreach (directed[k]) begin
            send_cmd(directed[k].cmd, 1'b1);
            if (directed[k].has_fixed) begin
                // the row just accepted is the newest queued prediction
                got = pending_results[pending_results.size() - 1];
                check_fixed(k, got, directed[k].fixed);
            end
        end
        drain_results();

        // random phases with different offsets
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_ROW_OFFSET, 16'h0000);
                    apb_write(REG_COL_OFFSET, 16'h0000);
                end
                1: begin
                    apb_write(REG_ROW_OFFSET, 16'hFFFF);
                    apb_write(REG_COL_OFFSET, 16'h0000);
                end
                2: begin
                    apb_write(REG_ROW_OFFSET, 16'($urandom));
                    apb_write(REG_COL_OFFSET, 16'hFFFF);
                end
                default: begin
                    apb_write(REG_ROW_OFFSET, 16'($urandom));
                    apb_write(REG_COL_OFFSET, 16'($urandom));
                end
            endcase
            no_idle = (ph == 2);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 1 && k == 10) hold_off = 1'b1;
                if (ph == 3 && k == 60) wait_results();
                c = rand_cmd($urandom_range(99) < 85);
                send_cmd(c, 1'b1);
                sent++;
            end
            no_idle = 1'b0;
            drain_results();
        end

        // fill the table to capacity with outer products of fresh keys
        send_cmd('{spoc_pkg::OP_AXA, 0, 0, 0, 0, 0, 0}, 1'b0);
        fill_round = 0;
        while (tbl_count < CAP) begin
            for (int k = 0; k < VMAX; k++) begin
                c = '{spoc_pkg::OP_PUSH_A, 0, 0, 0,
                      IDX_W'(16'h4000 + fill_round * VMAX + k), 32'h0001_0000, 0};
                send_cmd(c, 1'b0);
            end
            send_cmd('{spoc_pkg::OP_AXA, 0, 0, 0, 0, 0, 0}, 1'b0);
            fill_round++;
        end
        send_cmd('{spoc_pkg::OP_ADD, 15'h7FFE, 15'h7FFE, 64'd5, 0, 0, 0}, 1'b1);
        send_cmd('{spoc_pkg::OP_PUSH_A, 0, 0, 0, 15'h7FF0, 32'h0001_0000, 0}, 1'b1);
        send_cmd('{spoc_pkg::OP_PUSH_A, 0, 0, 0, 15'd0, 32'h0002_0000, 0}, 1'b1);
        send_cmd('{spoc_pkg::OP_PUSH_B, 0, 0, 0, 15'h4000, 32'hFFFF_0000, 0}, 1'b1);
        send_cmd('{spoc_pkg::OP_AXB, 0, 0, 0, 0, 0, 0}, 1'b1);
        send_cmd('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, '1}, 1'b1);
        send_cmd('{spoc_pkg::OP_READ, 0, 0, 0, 0, 0, 10'd0}, 1'b1);

        wait_results();
        repeat (50) @(negedge i_clk);
        if (error_count == 0)
            $display("PASS sparse_outer_product_accumulator");
        else
            $display("FAIL sparse_outer_product_accumulator");
        $finish;
    end

endmodule

### sim.f
rtl/spoc_pkg.sv
rtl/spoc_if.sv
rtl/spoc_entry_mem.sv
rtl/spoc_vec_store.sv
rtl/sparse_outer_product_accumulator.sv
bench/tb_sparse_outer_product_accumulator.sv
